// File: src/srsw_pkg.sv
// Shared types and constants for the selective-repeat sender window.
// No dependencies; imported by every module of the block.
`default_nettype none

package srsw_pkg;

  // Field and register widths
  localparam int unsigned TOTAL_W     = 26;
  localparam int unsigned TOTAL_MAX   = (1 << TOTAL_W) - 1;
  localparam int unsigned TIMEOUT_W   = 16;
  localparam int unsigned CFG_W       = 26;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned SEQ_FIELD_W = 16;
  localparam int unsigned LEN_FIELD_W = 11;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_SEND = 2'd0,
    OP_ACK  = 2'd1,
    OP_TICK = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    KIND_SEND        = 3'd0,
    KIND_RESEND      = 3'd1,
    KIND_FULL        = 3'd2,
    KIND_ALL_SENT    = 3'd3,
    KIND_ACK_TAKEN   = 3'd4,
    KIND_ACK_IGNORED = 3'd5
  } kind_t;

  typedef enum logic {
    REG_TOTAL_BYTES = 1'b0,
    REG_TIMEOUT     = 1'b1
  } reg_idx_t;

  // Classified request handed from front to back
  typedef struct packed {
    op_t                    op;
    logic [SEQ_FIELD_W-1:0] ack_seq;
  } cmd_t;

  // Register write
  typedef struct packed {
    logic             we;
    reg_idx_t         index;
    logic [CFG_W-1:0] data;
  } cfg_wr_t;

  // One result item
  typedef struct packed {
    kind_t                  kind;
    logic [SEQ_FIELD_W-1:0] seq;
    logic [LEN_FIELD_W-1:0] len;
    logic                   fin;
    logic [SEQ_FIELD_W-1:0] base;
    logic                   done;
    logic                   run_end;
  } res_t;

endpackage

`default_nettype wire

// File: src/srsw_front.sv
// Front stage: accepts requests, drops unknown operations, registers the command.
// Depends on srsw_pkg.
`default_nettype none

module srsw_front (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire  [srsw_pkg::OP_W-1:0]           in_operation,
  input  wire  [srsw_pkg::SEQ_FIELD_W-1:0]    in_ack_seq,
  output logic                                cmd_valid,
  input  wire                                 cmd_stall,
  output srsw_pkg::cmd_t                      cmd
);
  import srsw_pkg::*;

  logic cmd_valid_r, cmd_valid_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic take;
  logic known;

  // Hold off only while the stored command cannot move on
  assign in_stall = cmd_valid_r && cmd_stall;
  assign take     = in_valid && !in_stall;

  // Classify the operation code
  always_comb begin
    known = 1'b0;
    unique case (in_operation)
      OP_SEND, OP_ACK, OP_TICK: known = 1'b1;
      default:                  known = 1'b0;
    endcase
  end

  always_comb begin
    cmd_valid_nxt = cmd_valid_r;
    cmd_nxt       = cmd_r;
    if (take) begin
      cmd_valid_nxt   = known;
      cmd_nxt.op      = op_t'(in_operation);
      cmd_nxt.ack_seq = in_ack_seq;
    end else if (!cmd_stall) begin
      cmd_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
    end
    cmd_r <= cmd_nxt;
  end

  assign cmd_valid = cmd_valid_r;
  assign cmd       = cmd_r;

endmodule

`default_nettype wire

// File: src/srsw_cmd_fifo.sv
// Short command queue between the front stage and the back sequencer.
// Depends on srsw_pkg.
`default_nettype none

module srsw_cmd_fifo (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push_valid,
  output logic            push_stall,
  input  srsw_pkg::cmd_t  push_cmd,
  output logic            pop_valid,
  input  wire             pop_stall,
  output srsw_pkg::cmd_t  pop_cmd
);
  import srsw_pkg::*;

  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t               entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [COUNT_W-1:0] count_r;
  logic               push, pop;

  assign push_stall = (count_r == COUNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;
  assign pop_cmd    = entry_r[rd_ptr_r];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_cmd;
  end

endmodule

`default_nettype wire

// File: src/srsw_back.sv
// Back sequencer: window state, timers, slide and timer scan, result register.
// Depends on srsw_pkg.
`default_nettype none

module srsw_back #(
  parameter int WINDOW_SLOTS  = 8,
  parameter int SEGMENT_BYTES = 1024,
  parameter int SEQ_BITS      = 16
) (
  input  wire                clk,
  input  wire                rst_n,
  input  srsw_pkg::cfg_wr_t  cfg,
  input  wire                cmd_valid,
  output logic               cmd_stall,
  input  srsw_pkg::cmd_t     cmd,
  output logic               out_valid,
  input  wire                out_stall,
  output srsw_pkg::res_t     out_res
);
  import srsw_pkg::*;

  localparam int W         = WINDOW_SLOTS;
  localparam int SLOT_W    = (W > 1) ? $clog2(W) : 1;
  localparam int SUM_W     = SLOT_W + 1;
  localparam int unsigned MAX_PKTS = (TOTAL_MAX + SEGMENT_BYTES - 1) / SEGMENT_BYTES;
  localparam int CNT_W     = $clog2(MAX_PKTS + 1);
  localparam int SEG_W     = $clog2(SEGMENT_BYTES + 1);
  localparam int OFF_W     = CNT_W + SEG_W;
  localparam int WIDE_W    = ((OFF_W > TOTAL_W) ? OFF_W : TOTAL_W) + 1;
  localparam int SEQ_CMP_W = ((CNT_W > SEQ_FIELD_W) ? CNT_W : SEQ_FIELD_W) + 1;
  localparam int WIN_W     = ((CNT_W > 7) ? CNT_W : 7) + 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(W - 1);
  localparam logic [63:0] SEQ_MASK = (64'd1 << SEQ_BITS) - 64'd1;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SEND     = 9'b000000010,
    S_ACK_CHK  = 9'b000000100,
    S_ACK_CNT  = 9'b000001000,
    S_SLIDE    = 9'b000010000,
    S_ACK_EMIT = 9'b000100000,
    S_SCAN     = 9'b001000000,
    S_SUPD     = 9'b010000000,
    S_TEND     = 9'b100000000
  } state_t;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [SEQ_FIELD_W-1:0] seq_field(input logic [63:0] v);
    return SEQ_FIELD_W'(v & SEQ_MASK);
  endfunction

  // Control and window state
  state_t                 state_r, state_nxt;
  logic [TOTAL_W-1:0]     total_r, total_nxt;
  logic [TIMEOUT_W-1:0]   timeout_r, timeout_nxt;
  logic [CNT_W-1:0]       next_r, next_nxt;
  logic [CNT_W-1:0]       base_r, base_nxt;
  logic [CNT_W-1:0]       taken_r, taken_nxt;
  logic [SLOT_W-1:0]      next_slot_r, next_slot_nxt;
  logic [SLOT_W-1:0]      base_slot_r, base_slot_nxt;
  logic                   done_r, done_nxt;
  logic                   acked_r [W];
  logic                   acked_nxt [W];
  logic                   tvalid_r [W];
  logic                   tvalid_nxt [W];

  // Working registers
  logic [OFF_W-1:0]       off_r, off_nxt;
  logic [SEQ_FIELD_W-1:0] ack_r, ack_nxt;
  logic [CNT_W-1:0]       scan_q_r, scan_q_nxt;
  logic [SLOT_W-1:0]      scan_slot_r, scan_slot_nxt;
  logic                   pend_valid_r, pend_valid_nxt;
  logic [CNT_W-1:0]       pend_seq_r, pend_seq_nxt;
  logic [LEN_FIELD_W-1:0] pend_len_r, pend_len_nxt;
  logic                   pend_fin_r, pend_fin_nxt;

  // Result register
  logic                   out_valid_r, out_valid_nxt;
  res_t                   out_res_r, out_res_nxt;
  logic                   out_free;
  logic                   emit;
  res_t                   emit_res;

  // Timer memory
  logic [TIMEOUT_W-1:0]   timer_mem [W];
  logic [TIMEOUT_W-1:0]   rd_data_r;
  logic                   rd_en, mem_we;
  logic [TIMEOUT_W-1:0]   mem_wdata;

  // Shared constant multiplier: sequence number to byte offset
  logic                   mul_en;
  logic [CNT_W-1:0]       mul_in;
  logic [OFF_W-1:0]       mul_prod;

  // Datapath helpers
  logic [WIDE_W-1:0]      off_w, tot_w;
  logic                   past_end, seg_fin;
  logic [LEN_FIELD_W-1:0] seg_len;
  logic                   window_ok;
  logic [SEQ_CMP_W-1:0]   ack_w, base_w, next_w, ack_dist;
  logic [SUM_W-1:0]       ack_sum;
  logic [SLOT_W-1:0]      ack_slot;
  logic                   ack_in_range, ack_hit;
  logic [TIMEOUT_W-1:0]   t_cur, t_inc, limit;
  logic                   expire;

  assign out_free  = !out_valid_r || !out_stall;
  assign cmd_stall = (state_r != S_IDLE);
  assign mul_prod  = OFF_W'(mul_in) * OFF_W'(SEGMENT_BYTES);

  // Segment length and end-of-transfer tests from the registered offset
  always_comb begin
    off_w    = WIDE_W'(off_r);
    tot_w    = WIDE_W'(total_r);
    past_end = (off_w >= tot_w);
    seg_fin  = ((off_w + WIDE_W'(SEGMENT_BYTES)) >= tot_w);
    if (!seg_fin)            seg_len = LEN_FIELD_W'(SEGMENT_BYTES);
    else if (tot_w >= off_w) seg_len = LEN_FIELD_W'(tot_w - off_w);
    else                     seg_len = '0;
    window_ok = (WIN_W'(next_r) < (WIN_W'(base_r) + WIN_W'(W)));
  end

  // Ack window test; the slot follows from the distance to the base
  always_comb begin
    ack_w        = SEQ_CMP_W'(ack_r);
    base_w       = SEQ_CMP_W'(base_r);
    next_w       = SEQ_CMP_W'(next_r);
    ack_dist     = ack_w - base_w;
    ack_sum      = SUM_W'(base_slot_r) + SUM_W'(ack_dist);
    ack_slot     = (ack_sum >= SUM_W'(W)) ? SLOT_W'(ack_sum - SUM_W'(W)) : SLOT_W'(ack_sum);
    ack_in_range = (ack_w >= base_w) && (ack_w < next_w);
    ack_hit      = ack_in_range && !acked_r[ack_slot];
  end

  // Timer aging for the slot under scan
  always_comb begin
    t_cur  = tvalid_r[scan_slot_r] ? rd_data_r : '0;
    t_inc  = (t_cur != '1) ? t_cur + 1'b1 : t_cur;
    limit  = (timeout_r == '0) ? TIMEOUT_W'(1) : timeout_r;
    expire = (t_inc >= limit);
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    total_nxt      = total_r;
    timeout_nxt    = timeout_r;
    next_nxt       = next_r;
    base_nxt       = base_r;
    taken_nxt      = taken_r;
    next_slot_nxt  = next_slot_r;
    base_slot_nxt  = base_slot_r;
    done_nxt       = done_r;
    acked_nxt      = acked_r;
    tvalid_nxt     = tvalid_r;
    off_nxt        = off_r;
    ack_nxt        = ack_r;
    scan_q_nxt     = scan_q_r;
    scan_slot_nxt  = scan_slot_r;
    pend_valid_nxt = pend_valid_r;
    pend_seq_nxt   = pend_seq_r;
    pend_len_nxt   = pend_len_r;
    pend_fin_nxt   = pend_fin_r;
    mul_en         = 1'b0;
    mul_in         = next_r;
    rd_en          = 1'b0;
    mem_we         = 1'b0;
    mem_wdata      = '0;
    emit           = 1'b0;
    emit_res.kind    = KIND_SEND;
    emit_res.seq     = seq_field(64'(next_r));
    emit_res.len     = '0;
    emit_res.fin     = 1'b0;
    emit_res.base    = seq_field(64'(base_r));
    emit_res.done    = done_r;
    emit_res.run_end = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            OP_SEND: begin
              mul_en    = 1'b1;
              mul_in    = next_r;
              state_nxt = S_SEND;
            end
            OP_ACK: begin
              ack_nxt   = cmd.ack_seq;
              state_nxt = S_ACK_CHK;
            end
            OP_TICK: begin
              scan_q_nxt     = base_r;
              scan_slot_nxt  = base_slot_r;
              pend_valid_nxt = 1'b0;
              state_nxt      = S_SCAN;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      // Send request: all sent, new segment or window full
      S_SEND: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          if (past_end) begin
            emit_res.kind = KIND_ALL_SENT;
          end else if (window_ok) begin
            emit_res.kind           = KIND_SEND;
            emit_res.len            = seg_len;
            emit_res.fin            = seg_fin;
            acked_nxt[next_slot_r]  = 1'b0;
            tvalid_nxt[next_slot_r] = 1'b0;
            next_nxt                = next_r + CNT_W'(1);
            next_slot_nxt           = slot_inc(next_slot_r);
          end else begin
            emit_res.kind = KIND_FULL;
          end
        end
      end

      // Ack check; a fresh ack recomputes the done test
      S_ACK_CHK: begin
        if (ack_hit) begin
          acked_nxt[ack_slot] = 1'b1;
          taken_nxt           = taken_r + CNT_W'(1);
          mul_en              = 1'b1;
          mul_in              = taken_r + CNT_W'(1);
          state_nxt           = S_ACK_CNT;
        end else if (out_free) begin
          emit          = 1'b1;
          emit_res.kind = KIND_ACK_IGNORED;
          emit_res.seq  = seq_field(64'(ack_r));
          state_nxt     = S_IDLE;
        end
      end

      S_ACK_CNT: begin
        done_nxt  = past_end;
        state_nxt = S_SLIDE;
      end

      // Slide the base over acknowledged slots, one per cycle
      S_SLIDE: begin
        if ((base_r < next_r) && acked_r[base_slot_r]) begin
          acked_nxt[base_slot_r] = 1'b0;
          base_nxt               = base_r + CNT_W'(1);
          base_slot_nxt          = slot_inc(base_slot_r);
        end else begin
          state_nxt = S_ACK_EMIT;
        end
      end

      S_ACK_EMIT: begin
        if (out_free) begin
          emit          = 1'b1;
          emit_res.kind = KIND_ACK_TAKEN;
          emit_res.seq  = seq_field(64'(ack_r));
          state_nxt     = S_IDLE;
        end
      end

      // Tick scan: skip acked slots, read the timer of the others
      S_SCAN: begin
        if (scan_q_r >= next_r) begin
          state_nxt = S_TEND;
        end else if (acked_r[scan_slot_r]) begin
          scan_q_nxt    = scan_q_r + CNT_W'(1);
          scan_slot_nxt = slot_inc(scan_slot_r);
        end else begin
          rd_en     = 1'b1;
          mul_en    = 1'b1;
          mul_in    = scan_q_r;
          state_nxt = S_SUPD;
        end
      end

      // Age the timer; an expiry becomes the pending resend
      S_SUPD: begin
        if (!(expire && pend_valid_r && !out_free)) begin
          mem_we                  = 1'b1;
          mem_wdata               = expire ? '0 : t_inc;
          tvalid_nxt[scan_slot_r] = 1'b1;
          if (expire) begin
            if (pend_valid_r) begin
              emit             = 1'b1;
              emit_res.kind    = KIND_RESEND;
              emit_res.seq     = seq_field(64'(pend_seq_r));
              emit_res.len     = pend_len_r;
              emit_res.fin     = pend_fin_r;
              emit_res.run_end = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_seq_nxt   = scan_q_r;
            pend_len_nxt   = seg_len;
            pend_fin_nxt   = seg_fin;
          end
          scan_q_nxt    = scan_q_r + CNT_W'(1);
          scan_slot_nxt = slot_inc(scan_slot_r);
          state_nxt     = S_SCAN;
        end
      end

      // Last resend of the tick closes the run
      S_TEND: begin
        if (!pend_valid_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          emit           = 1'b1;
          emit_res.kind  = KIND_RESEND;
          emit_res.seq   = seq_field(64'(pend_seq_r));
          emit_res.len   = pend_len_r;
          emit_res.fin   = pend_fin_r;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (mul_en) off_nxt = mul_prod;

    // Register writes are to be made only while idle; the block does not enforce this
    if (cfg.we) begin
      unique case (cfg.index)
        REG_TOTAL_BYTES: begin
          total_nxt     = TOTAL_W'(cfg.data);
          next_nxt      = '0;
          base_nxt      = '0;
          taken_nxt     = '0;
          next_slot_nxt = '0;
          base_slot_nxt = '0;
          done_nxt      = (TOTAL_W'(cfg.data) == '0);
          for (int i = 0; i < W; i++) begin
            acked_nxt[i]  = 1'b0;
            tvalid_nxt[i] = 1'b0;
          end
        end
        REG_TIMEOUT: timeout_nxt = TIMEOUT_W'(cfg.data);
        default:     timeout_nxt = timeout_r;
      endcase
    end

    // Result register
    out_valid_nxt = emit ? 1'b1 : (out_valid_r && out_stall);
    out_res_nxt   = emit ? emit_res : out_res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      total_r      <= '0;
      timeout_r    <= TIMEOUT_RESET;
      next_r       <= '0;
      base_r       <= '0;
      taken_r      <= '0;
      next_slot_r  <= '0;
      base_slot_r  <= '0;
      done_r       <= 1'b1;
      acked_r      <= '{default: 1'b0};
      tvalid_r     <= '{default: 1'b0};
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      total_r      <= total_nxt;
      timeout_r    <= timeout_nxt;
      next_r       <= next_nxt;
      base_r       <= base_nxt;
      taken_r      <= taken_nxt;
      next_slot_r  <= next_slot_nxt;
      base_slot_r  <= base_slot_nxt;
      done_r       <= done_nxt;
      acked_r      <= acked_nxt;
      tvalid_r     <= tvalid_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    off_r       <= off_nxt;
    ack_r       <= ack_nxt;
    scan_q_r    <= scan_q_nxt;
    scan_slot_r <= scan_slot_nxt;
    pend_seq_r  <= pend_seq_nxt;
    pend_len_r  <= pend_len_nxt;
    pend_fin_r  <= pend_fin_nxt;
    out_res_r   <= out_res_nxt;
  end

  // Per-slot timer memory, one port used by the scan
  always_ff @(posedge clk) begin
    if (mem_we) timer_mem[scan_slot_r] <= mem_wdata;
    if (rd_en)  rd_data_r <= timer_mem[scan_slot_r];
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Outstanding segments never exceed the window
  a_window_span: assert property (@(posedge clk) disable iff (!rst_n)
    (base_r <= next_r) && ((WIN_W'(next_r) - WIN_W'(base_r)) <= WIN_W'(W)))
    else $error("window span exceeds slot count");

  // A pending resend exists only inside a tick scan
  a_pend_scope: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (state_r == S_SCAN || state_r == S_SUPD || state_r == S_TEND))
    else $error("pending resend outside tick scan");

  // Every new segment advances the next sequence number by one
  a_send_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_res.kind == KIND_SEND) |=> (next_r == $past(next_r) + CNT_W'(1)))
    else $error("send did not advance next sequence number");

  // The base only moves forward within a transfer
  a_base_forward: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg.we |=> (base_r >= $past(base_r)))
    else $error("window base moved backward");

endmodule

`default_nettype wire

// File: src/selective_repeat_sender_window.sv
// Selective-repeat sender window: top level joining front, queue and back.
// Depends on srsw_pkg, srsw_front, srsw_cmd_fifo and srsw_back.
//
// Usage:
//   Requests enter on in_valid/in_stall with in_operation (send, ack, tick)
//   and in_ack_seq. Results leave on out_valid/out_stall; a send or ack gives
//   one result, a tick one resend per expired timer or none, an unknown code
//   none. out_run_end marks the last result of a request.
//   Registers are to be written through cfg_we/cfg_index/cfg_wdata only while
//   idle (not enforced by the block); writing total_bytes starts a new transfer.
// Timing:
//   A request is registered in the front stage and queued; the back sequencer
//   pops it while idle, then emits a send or ignored ack from one state, runs
//   a taken ack through check, count, slide (per slid slot) and emit, and for
//   a tick scans the window, skipping acked slots and reading, then updating,
//   the timer of each unacked one; a receiver stall adds waiting. It handles one
//   request at a time and sets the throughput; the front and queue keep accepting.
// Reset: synchronous, active low; empty transfer, timeout of 100 ticks.
// A stalled receiver holds the result register; the back waits to emit,
// the queue fills, and then in_stall rises.
`default_nettype none

module selective_repeat_sender_window #(
  parameter int WINDOW_SLOTS  = 8,
  parameter int SEGMENT_BYTES = 1024,
  parameter int SEQ_BITS      = 16
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_we,
  input  wire  [0:0]                        cfg_index,
  input  wire  [srsw_pkg::CFG_W-1:0]        cfg_wdata,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  [srsw_pkg::OP_W-1:0]         in_operation,
  input  wire  [srsw_pkg::SEQ_FIELD_W-1:0]  in_ack_seq,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [2:0]                        out_kind,
  output logic [srsw_pkg::SEQ_FIELD_W-1:0]  out_seq_out,
  output logic [srsw_pkg::LEN_FIELD_W-1:0]  out_segment_length,
  output logic                              out_final_segment,
  output logic [srsw_pkg::SEQ_FIELD_W-1:0]  out_window_base,
  output logic                              out_transfer_done,
  output logic                              out_run_end
);
  import srsw_pkg::*;

  cmd_t    front_cmd, queue_cmd;
  logic    front_valid, front_stall;
  logic    queue_valid, queue_stall;
  cfg_wr_t cfg;
  res_t    res;

  assign cfg.we    = cfg_we;
  assign cfg.index = reg_idx_t'(cfg_index);
  assign cfg.data  = cfg_wdata;

  srsw_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_ack_seq   (in_ack_seq),
    .cmd_valid    (front_valid),
    .cmd_stall    (front_stall),
    .cmd          (front_cmd)
  );

  srsw_cmd_fifo u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_stall (front_stall),
    .push_cmd   (front_cmd),
    .pop_valid  (queue_valid),
    .pop_stall  (queue_stall),
    .pop_cmd    (queue_cmd)
  );

  srsw_back #(
    .WINDOW_SLOTS  (WINDOW_SLOTS),
    .SEGMENT_BYTES (SEGMENT_BYTES),
    .SEQ_BITS      (SEQ_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd_valid (queue_valid),
    .cmd_stall (queue_stall),
    .cmd       (queue_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_kind           = res.kind;
  assign out_seq_out        = res.seq;
  assign out_segment_length = res.len;
  assign out_final_segment  = res.fin;
  assign out_window_base    = res.base;
  assign out_transfer_done  = res.done;
  assign out_run_end        = res.run_end;

endmodule

`default_nettype wire
